[src/kcc_pkg.sv]
package kcc_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] REG_CONFIRM_GAP = 2'd0;
  localparam logic [1:0] REG_CLICK_MAX   = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd2;

  localparam logic [15:0] CONFIRM_GAP_RESET = 16'd300;
  localparam logic [15:0] CLICK_MAX_RESET   = 16'd1000;
  localparam logic [15:0] LONG_PRESS_RESET  = 16'd5000;

  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_MULTI  = 2'd2;
  localparam logic [1:0] KIND_LONG   = 2'd3;

  typedef struct packed {
    logic [2:0]  key_index;
    logic [1:0]  mode;
    logic [31:0] now_tick;
  } evt_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] click_count;
  } res_item_t;

  typedef struct packed {
    logic [31:0] mark_tick;
    logic [7:0]  run_count;
    logic        confirming;
  } key_state_t;

  typedef struct packed {
    logic [15:0] confirm_gap_ticks;
    logic [15:0] click_max_ticks;
    logic [15:0] long_press_ticks;
  } cfg_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

endpackage

[src/key_click_classifier.sv]
// Channel  Direction  Payload       Handshake
// evt      in         evt_item_t    evt_valid / evt_ready
// res      out        res_item_t    res_valid / res_ready
// cfg      in         APB 32 bit    psel / penable / pwrite, pready tied high
//
// A beat reads its key's state at acceptance, is classified in the next cycle
// and lands in the result register when the classify stage fires, which
// raises res_valid. One beat is taken per cycle while no result stalls; the
// per-key state write and read forwarding let consecutive beats on the same
// key follow. Reset is synchronous; it invalidates all key state, which then
// reads as zero, and sets the registers to their defaults. A stalled result
// holds the classify stage, which then holds evt_ready low.
module key_click_classifier #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         evt_valid,
  output logic                         evt_ready,
  input  kcc_pkg::evt_item_t           evt,
  output logic                         res_valid,
  input  logic                         res_ready,
  output kcc_pkg::res_item_t           res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kcc_pkg::CfgAddrW-1:0] paddr,
  input  logic [kcc_pkg::CfgDataW-1:0] pwdata,
  output logic [kcc_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import kcc_pkg::*;

  localparam int unsigned IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t       cfg;
  evt_item_t  s1_item;
  logic       s1_valid;
  logic       s1_in_range;
  logic       s1_fire;
  logic       evt_fire;
  logic       evt_in_range;
  key_state_t s1_state;
  key_state_t nxt_state;
  logic       nxt_wr;
  res_item_t  s1_res;

  assign evt_in_range = 32'(evt.key_index) < NUM_KEYS;
  assign s1_fire      = s1_valid && (!res_valid || res_ready);
  assign evt_ready    = !s1_valid || s1_fire;
  assign evt_fire     = evt_valid && evt_ready;

  kcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcc_keymem #(
    .NUM_KEYS (NUM_KEYS),
    .IDX_W    (IDX_W)
  ) u_keymem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (evt_fire),
    .rd_idx  (IDX_W'(evt.key_index)),
    .wr_en   (s1_fire && nxt_wr),
    .wr_idx  (IDX_W'(s1_item.key_index)),
    .wr_data (nxt_state),
    .rd_data (s1_state)
  );

  kcc_eval u_eval (
    .item     (s1_item),
    .in_range (s1_in_range),
    .cur      (s1_state),
    .cfg      (cfg),
    .nxt      (nxt_state),
    .wr_en    (nxt_wr),
    .res      (s1_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_ready) begin
      s1_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_fire) begin
      s1_item     <= evt;
      s1_in_range <= evt_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= s1_res;
    end
  end

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((res.event_kind == KIND_NONE) || (res.event_kind == KIND_LONG))
      |-> (res.click_count == 8'd0))
    else $error("click count set on a beat that is no click");

  a_single_one: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_kind == KIND_SINGLE) |-> (res.click_count == 8'd1))
    else $error("single click with a count other than one");

  a_multi_two: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_kind == KIND_MULTI) |-> (res.click_count >= 8'd2))
    else $error("multi-click with a count below two");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !res_ready |=> s1_valid && $stable(s1_item))
    else $error("classify stage lost its beat while the result stalled");

endmodule

[src/kcc_cfg.sv]
module kcc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kcc_pkg::CfgAddrW-1:0] paddr,
  input  logic [kcc_pkg::CfgDataW-1:0] pwdata,
  output logic [kcc_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  output kcc_pkg::cfg_t                cfg
);
  import kcc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_gap_ticks <= CONFIRM_GAP_RESET;
      cfg.click_max_ticks   <= CLICK_MAX_RESET;
      cfg.long_press_ticks  <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CONFIRM_GAP: cfg.confirm_gap_ticks <= pwdata[15:0];
        REG_CLICK_MAX:   cfg.click_max_ticks   <= pwdata[15:0];
        REG_LONG_PRESS:  cfg.long_press_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CONFIRM_GAP: prdata = {16'd0, cfg.confirm_gap_ticks};
      REG_CLICK_MAX:   prdata = {16'd0, cfg.click_max_ticks};
      REG_LONG_PRESS:  prdata = {16'd0, cfg.long_press_ticks};
      default:         prdata = '0;
    endcase
  end

endmodule

[src/kcc_keymem.sv]
module kcc_keymem #(
  parameter int unsigned NUM_KEYS = 8,
  parameter int unsigned IDX_W    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  kcc_pkg::key_state_t   wr_data,
  output kcc_pkg::key_state_t   rd_data
);
  import kcc_pkg::*;

  key_state_t           mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  entry_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  // A write in the same cycle as the read is forwarded so that back-to-back
  // beats on one key see the newest state.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_idx == rd_idx)) begin
        rd_data <= wr_data;
      end else if (entry_valid[rd_idx]) begin
        rd_data <= mem[rd_idx];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

[src/kcc_eval.sv]
module kcc_eval (
  input  kcc_pkg::evt_item_t  item,
  input  logic                in_range,
  input  kcc_pkg::key_state_t cur,
  input  kcc_pkg::cfg_t       cfg,
  output kcc_pkg::key_state_t nxt,
  output logic                wr_en,
  output kcc_pkg::res_item_t  res
);
  import kcc_pkg::*;

  logic [31:0] held;
  logic [7:0]  inc_count;

  assign held      = item.now_tick - cur.mark_tick;
  assign inc_count = sat_inc(cur.run_count);
  assign wr_en     = in_range;

  always_comb begin
    nxt             = cur;
    res.event_kind  = KIND_NONE;
    res.click_count = 8'd0;
    if (in_range) begin
      unique case (item.mode)
        MODE_PRESS: begin
          nxt.mark_tick = item.now_tick;
          nxt.run_count = cur.confirming ? inc_count : 8'd0;
        end
        MODE_RELEASE: begin
          if (held >= {16'd0, cfg.long_press_ticks}) begin
            res.event_kind = KIND_LONG;
            nxt.confirming = 1'b0;
          end else if (held <= {16'd0, cfg.click_max_ticks}) begin
            nxt.mark_tick  = item.now_tick;
            nxt.confirming = 1'b1;
          end else begin
            nxt.confirming = 1'b0;
          end
        end
        MODE_TICK: begin
          if (cur.confirming && (held >= {16'd0, cfg.confirm_gap_ticks})) begin
            nxt.run_count   = inc_count;
            nxt.confirming  = 1'b0;
            res.click_count = inc_count;
            res.event_kind  = (inc_count == 8'd1) ? KIND_SINGLE : KIND_MULTI;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sim/key_click_classifier_tb.sv]
module key_click_classifier_tb;
  import kcc_pkg::*;

  localparam int KEYS = 8;
  localparam int PHASES = 6;
  localparam int PHASE_BEATS = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    evt_item_t beat;
    bit        known;
    res_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                evt_valid = 1'b0;
  logic                evt_ready;
  evt_item_t           evt = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  res_item_t           res;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  logic [15:0] gap_cfg;
  logic [15:0] click_cfg;
  logic [15:0] long_cfg;
  logic [31:0] key_mark [KEYS];
  logic [7:0]  key_runs [KEYS];
  logic        key_armed [KEYS];

  res_item_t   pending_res [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          idle_pct = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] tick_now;

  key_click_classifier #(
    .NUM_KEYS(KEYS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("ERROR at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic res_item_t classify_event(input evt_item_t b);
    res_item_t   r;
    logic [31:0] held;
    int          k;
    r = '0;
    k = int'(b.key_index);
    if (k < KEYS) begin
      held = b.now_tick - key_mark[k];
      case (b.mode)
        MODE_PRESS: begin
          key_mark[k] = b.now_tick;
          if (!key_armed[k]) begin
            key_runs[k] = 8'd0;
          end else if (key_runs[k] != 8'hff) begin
            key_runs[k] = key_runs[k] + 8'd1;
          end
        end
        MODE_RELEASE: begin
          if (held >= {16'd0, long_cfg}) begin
            r.event_kind = KIND_LONG;
            key_armed[k] = 1'b0;
          end else if (held <= {16'd0, click_cfg}) begin
            key_mark[k] = b.now_tick;
            key_armed[k] = 1'b1;
          end else begin
            key_armed[k] = 1'b0;
          end
        end
        MODE_TICK: begin
          if (key_armed[k] && held >= {16'd0, gap_cfg}) begin
            if (key_runs[k] != 8'hff) begin
              key_runs[k] = key_runs[k] + 8'd1;
            end
            r.click_count = key_runs[k];
            r.event_kind = (key_runs[k] == 8'd1) ? KIND_SINGLE : KIND_MULTI;
            key_armed[k] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_beat(input evt_item_t b, input bit known, input res_item_t want);
    res_item_t predicted;
    int        gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      evt_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt <= b;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    predicted = classify_event(b);
    pending_res.push_back(known ? want : predicted);
    beats_sent++;
  endtask

  task automatic send_evt(input logic [2:0] k, input logic [1:0] m, input logic [31:0] t);
    evt_item_t b;
    b.key_index = k;
    b.mode = m;
    b.now_tick = t;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic add_row(input logic [2:0] k, input logic [1:0] m, input logic [31:0] t,
                         input bit known, input logic [1:0] kind, input logic [7:0] cnt);
    dir_row_t row;
    row.beat.key_index = k;
    row.beat.mode = m;
    row.beat.now_tick = t;
    row.known = known;
    row.want.event_kind = kind;
    row.want.click_count = cnt;
    dir_rows.push_back(row);
  endtask

  task automatic drain();
    evt_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CONFIRM_GAP: gap_cfg = val;
      REG_CLICK_MAX:   click_cfg = val;
      REG_LONG_PRESS:  long_cfg = val;
      default: begin
      end
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] != val) begin
      report_mismatch($sformatf("register %0d reads %0d, written %0d", idx, prdata[15:0], val));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] short_hold();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return {16'd0, click_cfg};
      default: return $urandom_range(0, int'(click_cfg));
    endcase
  endfunction

  function automatic logic [31:0] long_hold();
    case ($urandom_range(0, 3))
      0: return {16'd0, long_cfg};
      1: return $urandom | 32'h0001_0000;
      default: return {16'd0, long_cfg} + $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [31:0] mid_hold();
    if (int'(long_cfg) > int'(click_cfg) + 1) begin
      return $urandom_range(int'(click_cfg) + 1, int'(long_cfg) - 1);
    end
    return $urandom_range(int'(click_cfg) + 1, int'(click_cfg) + 100);
  endfunction

  task automatic click_run(input logic [2:0] k, input int clicks);
    int i;
    for (i = 0; i < clicks; i++) begin
      send_evt(k, MODE_PRESS, tick_now);
      tick_now += short_hold();
      send_evt(k, MODE_RELEASE, tick_now);
      if (gap_cfg != 16'd0 && $urandom_range(0, 3) == 0) begin
        send_evt(k, MODE_TICK, tick_now + $urandom_range(0, int'(gap_cfg) - 1));
      end
      if (i < clicks - 1) begin
        tick_now += $urandom_range(0, int'(gap_cfg));
      end
    end
    tick_now += {16'd0, gap_cfg};
    if ($urandom_range(0, 2) != 0) begin
      tick_now += $urandom_range(0, 400);
    end
    send_evt(k, MODE_TICK, tick_now);
  endtask

  task automatic hold_and_release(input logic [2:0] k, input logic [31:0] hold_ticks);
    send_evt(k, MODE_PRESS, tick_now);
    tick_now += hold_ticks;
    send_evt(k, MODE_RELEASE, tick_now);
    if ($urandom_range(0, 1) == 0) begin
      send_evt(k, MODE_TICK, tick_now + $urandom_range(0, 2 * int'(gap_cfg)));
    end
    tick_now += $urandom_range(1, 50);
  endtask

  task automatic run_sequence();
    logic [2:0]  k;
    logic [31:0] t;
    int          pick;
    k = 3'($urandom_range(0, KEYS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      click_run(k, $urandom_range(5, 12));
    end else if (pick < 50) begin
      click_run(k, $urandom_range(1, 4));
    end else if (pick < 65) begin
      hold_and_release(k, long_hold());
    end else if (pick < 75) begin
      hold_and_release(k, mid_hold());
    end else begin
      t = ($urandom_range(0, 1) == 0) ? $urandom : tick_now + $urandom_range(0, 100);
      send_evt(k, 2'($urandom_range(0, 3)), t);
    end
  endtask

  task automatic check_result(input res_item_t r);
    res_item_t w;
    if (pending_res.size() == 0) begin
      report_mismatch($sformatf("result kind %0d count %0d with nothing expected",
                                r.event_kind, r.click_count));
      return;
    end
    w = pending_res.pop_front();
    if (r.event_kind != w.event_kind) begin
      report_mismatch($sformatf("event_kind %0d, expected %0d", r.event_kind, w.event_kind));
    end
    if (r.click_count != w.click_count) begin
      report_mismatch($sformatf("click_count %0d, expected %0d", r.click_count, w.click_count));
    end
  endtask

  // The receiver takes one result beat per ready edge and stalls in random bursts.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        check_result(res);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 80;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL key_click_classifier");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] ph_gap [PHASES];
    logic [15:0] ph_click [PHASES];
    logic [15:0] ph_long [PHASES];
    logic [2:0]  k;
    int          p;
    int          i;
    int          seqs;
    int          start;

    gap_cfg = CONFIRM_GAP_RESET;
    click_cfg = CLICK_MAX_RESET;
    long_cfg = LONG_PRESS_RESET;
    for (i = 0; i < KEYS; i++) begin
      key_mark[i] = '0;
      key_runs[i] = '0;
      key_armed[i] = 1'b0;
    end

    ph_gap[0] = CONFIRM_GAP_RESET;
    ph_click[0] = CLICK_MAX_RESET;
    ph_long[0] = LONG_PRESS_RESET;
    ph_gap[1] = 16'hffff;
    ph_click[1] = 16'hffff;
    ph_long[1] = 16'hffff;
    ph_gap[2] = 16'd0;
    ph_click[2] = 16'd0;
    ph_long[2] = 16'd0;
    ph_gap[3] = 16'($urandom_range(0, 65535));
    ph_click[3] = 16'($urandom_range(0, 65535));
    ph_long[3] = 16'($urandom_range(0, 65535));
    ph_gap[4] = 16'd0;
    ph_click[4] = 16'hffff;
    ph_long[4] = 16'd1;
    ph_gap[5] = 16'($urandom_range(1, 400));
    ph_click[5] = 16'($urandom_range(1, 2000));
    ph_long[5] = 16'($urandom_range(2000, 8000));

    add_row(3'd0, MODE_TICK,    32'd0,          1'b1, KIND_NONE,   8'd0);
    add_row(3'd0, MODE_PRESS,   32'd16,         1'b0, KIND_NONE,   8'd0);
    add_row(3'd0, MODE_RELEASE, 32'd1016,       1'b0, KIND_NONE,   8'd0);
    add_row(3'd0, MODE_TICK,    32'd1315,       1'b1, KIND_NONE,   8'd0);
    add_row(3'd0, MODE_TICK,    32'd1316,       1'b1, KIND_SINGLE, 8'd1);
    add_row(3'd1, MODE_PRESS,   32'd100,        1'b0, KIND_NONE,   8'd0);
    add_row(3'd1, MODE_RELEASE, 32'd5100,       1'b1, KIND_LONG,   8'd0);
    add_row(3'd2, MODE_PRESS,   32'd200,        1'b0, KIND_NONE,   8'd0);
    add_row(3'd2, MODE_RELEASE, 32'd1201,       1'b1, KIND_NONE,   8'd0);
    add_row(3'd2, MODE_TICK,    32'd5000,       1'b1, KIND_NONE,   8'd0);
    add_row(3'd4, MODE_PRESS,   32'hffff_ff00,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd4, MODE_RELEASE, 32'h0000_0040,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd4, MODE_PRESS,   32'h0000_0050,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd4, MODE_RELEASE, 32'h0000_0060,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd4, MODE_TICK,    32'h0000_018c,  1'b1, KIND_MULTI,  8'd2);
    add_row(3'd7, MODE_UNUSED,  32'hffff_ffff,  1'b1, KIND_NONE,   8'd0);
    add_row(3'd5, MODE_PRESS,   32'd10,         1'b0, KIND_NONE,   8'd0);
    add_row(3'd5, MODE_RELEASE, 32'd20,         1'b0, KIND_NONE,   8'd0);
    add_row(3'd5, MODE_PRESS,   32'd30,         1'b0, KIND_NONE,   8'd0);
    add_row(3'd5, MODE_TICK,    32'd400,        1'b1, KIND_MULTI,  8'd2);
    add_row(3'd5, MODE_RELEASE, 32'd420,        1'b0, KIND_NONE,   8'd0);
    add_row(3'd6, MODE_PRESS,   32'hffff_ffff,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd6, MODE_RELEASE, 32'hffff_ffff,  1'b0, KIND_NONE,   8'd0);
    add_row(3'd6, MODE_TICK,    32'hffff_ffff,  1'b1, KIND_NONE,   8'd0);
    add_row(3'd3, MODE_RELEASE, 32'd4999,       1'b1, KIND_NONE,   8'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tick_now = $urandom;
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(REG_CONFIRM_GAP, ph_gap[p]);
        write_reg(REG_CLICK_MAX, ph_click[p]);
        write_reg(REG_LONG_PRESS, ph_long[p]);
      end
      calm = (p == PHASES - 1);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);

      if (p == 0) begin
        foreach (dir_rows[j]) begin
          send_beat(dir_rows[j].beat, dir_rows[j].known, dir_rows[j].want);
        end
        // One short release arms the key; every later press extends the run
        // until the count pins at its ceiling.
        k = 3'($urandom_range(0, KEYS - 1));
        send_evt(k, MODE_PRESS, tick_now);
        tick_now += short_hold();
        send_evt(k, MODE_RELEASE, tick_now);
        for (i = 0; i < 257; i++) begin
          tick_now += $urandom_range(0, 50);
          send_evt(k, MODE_PRESS, tick_now);
        end
        tick_now += {16'd0, gap_cfg};
        send_evt(k, MODE_TICK, tick_now);
      end

      start = beats_sent;
      seqs = 0;
      while (beats_sent - start < PHASE_BEATS) begin
        if (seqs == 10 && p == 1) begin
          hold_req = 1'b1;
        end
        if (seqs == 10 && p == 2) begin
          drain();
        end
        run_sequence();
        seqs++;
      end
    end

    evt_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS key_click_classifier");
    end else begin
      $display("FAIL key_click_classifier");
    end
    $finish;
  end

endmodule
